/* hdl/caom_pkg.sv */
// shared constants and types of the current average overload monitor
package caom_pkg;

    localparam int RING_DEPTH   = 16;   // power of two, 4 to 256
    localparam int AVERAGE_SPAN = 10;
    localparam int OVERLOAD_RUN = 3;

    localparam int DATA_W = 16;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_MAX = (AVERAGE_SPAN > OVERLOAD_RUN) ? AVERAGE_SPAN : OVERLOAD_RUN;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);

    // window sum and reciprocal for the divide by the span
    localparam int SUM_W     = DATA_W + $clog2(AVERAGE_SPAN);
    localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_SPAN);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(AVERAGE_SPAN) - 64'd1) / 64'(AVERAGE_SPAN);

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam recip_t DIV_RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam data_t THRESHOLD_RESET = 16'd5000;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_APPEND = 1'b1;

endpackage

/* hdl/caom_in_if.sv */
// input channel: request type and current sample
interface caom_in_if;
    import caom_pkg::*;

    logic  valid;
    logic  ready;
    logic  req_type;
    data_t sample_milliamps;

    modport source (output valid, output req_type, output sample_milliamps, input ready);
    modport sink   (input valid, input req_type, input sample_milliamps, output ready);
endinterface

/* hdl/caom_out_if.sv */
// output channel: newest average and overload flag
interface caom_out_if;
    import caom_pkg::*;

    logic  valid;
    logic  ready;
    data_t latest_average;
    logic  overload;

    modport source (output valid, output latest_average, output overload, input ready);
    modport sink   (input valid, input latest_average, input overload, output ready);
endinterface

/* hdl/current_average_overload_monitor_core.sv */
// top level of the current average overload monitor
//
// One word is taken at a time; ready is high only while the sequencer is idle.
// A sample word goes straight to the overload check; an append word runs through
// the window sum, the divide, the history write and the overload check. Either
// way, the result is then loaded into the output register. Each ring has
// one read port, so the window sum reads one sample a cycle through a single
// accumulator, the divide by the span is one registered reciprocal multiply, and
// the overload check reads one history entry a cycle through a single comparator.
// The result sits in an output register, so the next word is accepted while it
// waits. Both rings read as zero after reset through per-entry valid bits; no
// clearing pass is needed.
module current_average_overload_monitor_core (
    input  logic             clk,
    input  logic             rst_n,
    caom_in_if.sink          in_ch,
    caom_out_if.source       out_ch,
    input  logic             cfg_wr_en,
    input  caom_pkg::data_t  cfg_wr_data
);
    import caom_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    data_t      thr_reg;
    ptr_t       sptr_reg, sptr_next;
    ptr_t       aptr_reg, aptr_next;
    cnt_t       cnt_reg, cnt_next;
    logic       rd_pend_reg, rd_pend_next;
    logic       first_reg, first_next;
    logic       over_reg, over_next;
    data_t      latest_reg, latest_next;
    sum_t       acc_reg, acc_next;
    prod_t      prod_reg, prod_next;
    logic       out_valid_reg, out_valid_next;
    data_t      out_avg_reg, out_avg_next;
    logic       out_ovl_reg, out_ovl_next;

    logic  in_fire;
    logic  s_wr_en;
    logic  a_wr_en;
    ptr_t  rd_off;
    ptr_t  s_rd_addr;
    ptr_t  a_rd_addr;
    data_t s_rd_data;
    data_t a_rd_data;
    data_t quotient;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // slot behind the pointer by cnt + 1, wrapping with the pointer width
    assign rd_off    = ptr_t'(cnt_reg) + ptr_t'(1);
    assign s_rd_addr = sptr_reg - rd_off;
    assign a_rd_addr = aptr_reg - rd_off;

    assign s_wr_en  = in_fire && (in_ch.req_type == REQ_SAMPLE);
    assign a_wr_en  = (state_reg == S_WR);
    assign quotient = prod_reg[DIV_SHIFT +: DATA_W];

    caom_ring u_sample_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s_wr_en),
        .wr_addr (sptr_reg),
        .wr_data (in_ch.sample_milliamps),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    caom_ring u_average_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (a_wr_en),
        .wr_addr (aptr_reg),
        .wr_data (quotient),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        sptr_next      = sptr_reg;
        aptr_next      = aptr_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        first_next     = first_reg;
        over_next      = over_reg;
        latest_next    = latest_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_ovl_next   = out_ovl_reg;

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                over_next  = 1'b1;
                first_next = 1'b1;
                if (in_fire)
                begin
                    if (in_ch.req_type == REQ_SAMPLE)
                    begin
                        sptr_next  = sptr_reg + ptr_t'(1);
                        state_next = S_RUN;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + sum_t'(s_rd_data);
                end
                if (cnt_reg < cnt_t'(AVERAGE_SPAN))
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + cnt_t'(1);
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod_t'(acc_reg) * prod_t'(DIV_RECIP);
                state_next = S_WR;
            end
            S_WR:
            begin
                // history write happens on this edge
                aptr_next  = aptr_reg + ptr_t'(1);
                cnt_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (rd_pend_reg)
                begin
                    over_next  = over_reg && (a_rd_data >= thr_reg);
                    first_next = 1'b0;
                    if (first_reg)
                    begin
                        latest_next = a_rd_data;
                    end
                end
                if (cnt_reg < cnt_t'(OVERLOAD_RUN))
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + cnt_t'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = latest_reg;
                    out_ovl_next   = over_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THRESHOLD_RESET;
            sptr_reg      <= '0;
            aptr_reg      <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sptr_reg      <= sptr_next;
            aptr_reg      <= aptr_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        over_reg    <= over_next;
        latest_reg  <= latest_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        out_avg_reg <= out_avg_next;
        out_ovl_reg <= out_ovl_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.latest_average = out_avg_reg;
    assign out_ch.overload       = out_ovl_reg;

endmodule

/* hdl/caom_ring.sv */
// ring memory with per-entry valid bits and a registered read port
module caom_ring (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  caom_pkg::ptr_t wr_addr,
    input  caom_pkg::data_t wr_data,
    input  caom_pkg::ptr_t rd_addr,
    output caom_pkg::data_t rd_data
);
    import caom_pkg::*;

    data_t                 mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] vld_reg;
    data_t                 rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // an entry never written reads as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
